### hw/rtl/modexp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;
	localparam int BASE_W  = 63;
	localparam int POWER_W = 64;
	localparam int MOD_W   = 63;
	localparam int RES_W   = 63;
endpackage
`default_nettype wire

### hw/rtl/modexp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_req_if / modexp_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface modexp_req_if;
	import modexp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [BASE_W-1:0]    base_value;
	logic [POWER_W-1:0]   power_value;
	logic [MOD_W-1:0]     modulus_value;
	modport source (output valid, base_value, power_value, modulus_value, input ready);
	modport sink   (input valid, base_value, power_value, modulus_value, output ready);
endinterface

interface modexp_rsp_if;
	import modexp_pkg::*;
	logic              valid;
	logic              ready;
	logic [RES_W-1:0]  power_result;
	modport source (output valid, power_result, input ready);
	modport sink   (input valid, power_result, output ready);
endinterface
`default_nettype wire

### hw/rtl/modular_exponentiation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^power mod modulus, right-to-left square-and-multiply with
// a bit-serial interleaved modular multiplier.
//
// Channels: req (sink) takes base_value, power_value, modulus_value;
// rsp (source) gives power_result, one per request.
// The exponent bits are handled LSB first. Each exponent bit costs one
// check state, one squaring and, for a set bit, one multiply; each product
// runs bit-serially on a shared double-and-add unit. The base is first
// pre-reduced mod modulus by a separate bit-serial shift-and-subtract step.
// Zero exponent or zero modulus skip the computation. One request at a time.
// The result waits in an output register; a new request is taken only once
// it has been delivered, so a stalled receiver holds the block.
// Reset clears the control state and drops any request in progress.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
	parameter int MOD_BITS = 63
) (
	input  wire logic clk,
	input  wire logic arst_n,
	modexp_req_if.sink   req,
	modexp_rsp_if.source rsp
);
	import modexp_pkg::*;

	localparam int MW = MOD_BITS + 1;
	localparam int CW = $clog2(MOD_BITS + 1);

	typedef enum logic [2:0] {S_IDLE, S_RED, S_CHK, S_MUL, S_SQR, S_DONE} state_t;
	state_t state_q;

	logic [MW-1:0]      m_q, base_q, acc_q, x_q, y_q, p_q;
	logic [POWER_W-1:0] e_q;
	logic [CW-1:0]      cnt_q;
	logic [RES_W-1:0]   res_q;
	logic               vld_q;

	// one double-and-add step: p = 2p (+ x) mod m
	logic [MW:0] dbl, dsub, sum, ssub;
	logic [MW-1:0] p_d, p_next;
	always_comb begin
		dbl = {p_q, 1'b0};
		dsub = dbl - {1'b0, m_q};
		p_d = dsub[MW] ? dbl[MW-1:0] : dsub[MW-1:0];
		sum = {1'b0, p_d} + {1'b0, x_q};
		ssub = sum - {1'b0, m_q};
		p_next = (y_q[MOD_BITS-1]) ? (ssub[MW] ? sum[MW-1:0] : ssub[MW-1:0]) : p_d;
	end

	// reduction step: shift in one base bit, subtract if >= m
	logic [MW:0] rsh, rsub;
	logic [MW-1:0] r_next;
	always_comb begin
		rsh = {p_q, y_q[MOD_BITS-1]};
		rsub = rsh - {1'b0, m_q};
		r_next = rsub[MW] ? rsh[MW-1:0] : rsub[MW-1:0];
	end

	logic last;
	assign last = (cnt_q == CW'(MOD_BITS - 1));

	assign req.ready = (state_q == S_IDLE) && !vld_q;
	assign rsp.valid = vld_q;
	assign rsp.power_result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (rsp.valid && rsp.ready) vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						m_q   <= {1'b0, req.modulus_value[MOD_BITS-1:0]};
						y_q   <= {1'b0, req.base_value[MOD_BITS-1:0]};
						e_q   <= req.power_value;
						p_q   <= '0;
						cnt_q <= '0;
						if (req.modulus_value[MOD_BITS-1:0] == '0) begin
							res_q <= '0;
							state_q <= S_DONE;
						end else if (req.power_value == '0) begin
							res_q <= RES_W'(1);
							state_q <= S_DONE;
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					p_q <= r_next;
					y_q <= {y_q[MW-2:0], 1'b0};
					if (last) begin
						cnt_q <= '0;
						base_q <= r_next;
						acc_q <= (m_q == MW'(1)) ? '0 : MW'(1);
						state_q <= S_CHK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CHK: begin
					p_q <= '0;
					cnt_q <= '0;
					if (e_q == '0) begin
						res_q <= RES_W'(acc_q);
						state_q <= S_DONE;
					end else if (e_q[0]) begin
						x_q <= acc_q;
						y_q <= base_q;
						state_q <= S_MUL;
					end else begin
						x_q <= base_q;
						y_q <= base_q;
						state_q <= S_SQR;
					end
				end
				S_MUL: begin
					if (last) begin
						acc_q <= p_next;
						p_q <= '0;
						cnt_q <= '0;
						x_q <= base_q;
						y_q <= base_q;
						state_q <= S_SQR;
					end else begin
						p_q <= p_next;
						y_q <= {y_q[MW-2:0], 1'b0};
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQR: begin
					p_q <= p_next;
					y_q <= {y_q[MW-2:0], 1'b0};
					if (last) begin
						cnt_q <= '0;
						base_q <= p_next;
						e_q <= e_q >> 1;
						state_q <= S_CHK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					vld_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.power_result))
		else $error("result dropped while stalled");
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> !req.ready)
		else $error("request taken with result pending");
	a_red: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> acc_q < m_q && base_q < m_q)
		else $error("operand not reduced");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MOD_BITS - 1))
		else $error("step counter overflow");
endmodule
`default_nettype wire

### sim/tb_modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking bench for the modular exponentiation block: directed corner
// requests, then random requests under several sender/receiver idle mixes,
// each result checked against an exact square-and-multiply computation.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
	import modexp_pkg::*;

	localparam int MAX_CYCLES = 12_000_000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   cycle_count;
	int   send_idle_pct;
	int   recv_stall_pct;

	logic [RES_W-1:0] expected_results[$];

	modexp_req_if req ();
	modexp_rsp_if rsp ();

	modular_exponentiation i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [MOD_W-1:0] mul_mod(logic [MOD_W-1:0] a, logic [MOD_W-1:0] b,
		logic [MOD_W-1:0] m);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b);
		return MOD_W'(prod % 128'(m));
	endfunction

	function automatic logic [RES_W-1:0] power_mod(logic [BASE_W-1:0] b,
		logic [POWER_W-1:0] e, logic [MOD_W-1:0] m);
		logic [MOD_W-1:0] acc;
		logic [MOD_W-1:0] sq;
		if (m == 0)
			return '0;
		if (e == 0)
			return RES_W'(1);
		acc = (m == 1) ? '0 : MOD_W'(1);
		sq  = MOD_W'(b % m);
		while (e != 0) begin
			if (e[0])
				acc = mul_mod(acc, sq, m);
			sq = mul_mod(sq, sq, m);
			e  = e >> 1;
		end
		return RES_W'(acc);
	endfunction

	// caller is at a falling edge; returns at a falling edge
	task automatic send_request(logic [BASE_W-1:0] b, logic [POWER_W-1:0] e,
		logic [MOD_W-1:0] m);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid         <= 1'b1;
		req.base_value    <= b;
		req.power_value   <= e;
		req.modulus_value <= m;
		do
			@(posedge clk);
		while (!req.ready);
		expected_results = {expected_results, power_mod(b, e, m)};
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// mostly short exponents to keep the run short; a few full-width ones
	function automatic logic [POWER_W-1:0] rand_power();
		int len;
		if ($urandom_range(9) == 0)
			return rand64();
		len = $urandom_range(16, 1);
		return rand64() & ((64'd1 << len) - 1);
	endfunction

	task automatic test_directed();
		logic [62:0] all_ones;
		all_ones = '1;
		send_request(63'd5, 64'd0, 63'd1);
		send_request(63'd0, 64'd0, 63'd7);
		send_request(63'd0, 64'd5, 63'd7);
		send_request(63'd3, 64'd4, 63'd0);
		send_request(all_ones, '1, 63'd0);
		send_request(63'd9, 64'd3, 63'd1);
		send_request(63'd2, 64'd10, 63'd1000);
		send_request(63'd100, 64'd3, 63'd7);
		send_request(all_ones, 64'd2, 63'd13);
		send_request(all_ones, '1, all_ones);
		send_request(all_ones - 1, '1, all_ones);
		send_request(63'd2, 64'h8000_0000_0000_0000, all_ones);
		send_request(63'd3, '1, 63'h4000_0000_0000_0001);
		send_request(63'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			63'h2AAA_AAAA_AAAA_AAAB);
		send_request(63'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			63'h5555_5555_5555_5555);
		send_request(63'd7, 64'd1, 63'd7);
		send_request(63'd1, '1, 63'd2);
		send_request(63'd0, 64'd1, all_ones);
	endtask

	task automatic test_random(int idle_pct, int stall_pct, int count);
		logic [MOD_W-1:0] m;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			case ($urandom_range(9))
				0: m = MOD_W'($urandom_range(255, 1));
				1: m = '0;
				default: m = MOD_W'(rand64());
			endcase
			send_request(BASE_W'(rand64()), rand_power(), m);
		end
	endtask

	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result power_result=%0h", rsp.power_result);
				fail_count++;
			end else begin
				if (rsp.power_result !== expected_results[0]) begin
					$error("power_result expected %0h actual %0h",
						expected_results[0], rsp.power_result);
					fail_count++;
				end
				void'(expected_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("modular_exponentiation verification failed");
			$finish;
		end
	end

	initial begin
		fail_count        = 0;
		cycle_count       = 0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		arst_n            = 1'b0;
		req.valid         = 1'b0;
		req.base_value    = '0;
		req.power_value   = '0;
		req.modulus_value = '0;
		rsp.ready         = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(0, 0, 30);
		test_random(53, 0, 30);
		test_random(0, 53, 30);
		test_random(12, 12, 30);
		req.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		recv_stall_pct = 0;
		repeat (20) @(negedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("modular_exponentiation verification clean");
		else
			$display("modular_exponentiation verification failed");
		$finish;
	end
endmodule
